[rtl/rmst_pkg.sv]
// ----------------------------------------------------------------------------
// rmst_pkg: shared types and constants for the range minimum segment tree
// Field widths, command codes, output limits and the sequencer state type.
// ----------------------------------------------------------------------------
package rmst_pkg;

  localparam int unsigned POS_W  = 11;  // position, range bounds, array length
  localparam int unsigned DATA_W = 32;  // set value and result value

  localparam logic CMD_SET   = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [POS_W-1:0] ARRAY_LEN_RST = 11'd1024;

  localparam logic signed [63:0]       OUT_MAX64 = 64'sd2147483647;
  localparam logic signed [63:0]       OUT_MIN64 = -64'sd2147483648;
  localparam logic signed [DATA_W-1:0] OUT_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] OUT_MIN   = 32'sh8000_0000;

  typedef enum logic [9:0] {
    ST_CLEAR  = 10'b00_0000_0001,
    ST_IDLE   = 10'b00_0000_0010,
    ST_S_LEAF = 10'b00_0000_0100,
    ST_S_RDL  = 10'b00_0000_1000,
    ST_S_RDR  = 10'b00_0001_0000,
    ST_S_WR   = 10'b00_0010_0000,
    ST_Q_CHK  = 10'b00_0100_0000,
    ST_Q_R    = 10'b00_1000_0000,
    ST_Q_SH   = 10'b01_0000_0000,
    ST_FIN    = 10'b10_0000_0000
  } state_e;

endpackage

[rtl/range_minimum_segment_tree.sv]
// ----------------------------------------------------------------------------
// range_minimum_segment_tree: min-tree with point set and range minimum query
// Bottom-up segment tree in one single-port memory, walked by a sequencer.
// ----------------------------------------------------------------------------
// Usage: a request enters on s_axis. tuser carries the command (set or query);
// tdata carries position, value, range_low and range_high. Each request yields
// one result on m_axis: tdata is the minimum (the largest value for a set, an
// empty range or a rejected request), tuser is the error flag. The cfg channel
// writes array_length; it is always ready.
// Sequence with L = ceil(log2(2*MAX_LEN)) - 1 tree levels above the leaves
// (10 for MAX_LEN = 1024): a set writes the leaf, then reads left, reads
// right and writes per level; a query, per level, reads left, reads right,
// folds and moves up. A rejected request or an empty range goes straight to
// its result. The next request can be taken in the cycle after a result is
// loaded, even while it waits in the output register. If the receiver
// stalls, the result holds and a finished request waits until the register
// frees. After reset a clearing pass writes the largest value into all
// 2*MAX_LEN nodes, one per cycle; no request is accepted meanwhile;
// configuration writes are taken.
// ----------------------------------------------------------------------------
module range_minimum_segment_tree
  import rmst_pkg::*;
#(
  parameter int unsigned MAX_LEN    = 1024,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Configuration: array_length
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [POS_W-1:0]  cfg_data_i,
  // Requests
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // tdata: position[10:0], value[42:11], range_low[53:43], range_high[64:54]
  input  logic [71:0]       s_axis_tdata,
  // tuser: command[0]
  input  logic              s_axis_tuser,
  // Results
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // tdata: min_value[31:0]
  output logic [DATA_W-1:0] m_axis_tdata,
  // tuser: error[0]
  output logic              m_axis_tuser
);

  localparam int unsigned TREE_SIZE = 2 * MAX_LEN;
  localparam int unsigned IDX_W     = $clog2(TREE_SIZE);
  localparam int unsigned CNT_W     = $clog2(TREE_SIZE + 1);
  localparam int unsigned EXT_W     = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic signed [VALUE_BITS-1:0] VMAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic signed [VALUE_BITS-1:0] VMIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam logic signed [63:0] VMAX64 = (64'sd1 <<< (VALUE_BITS - 1)) - 64'sd1;
  localparam logic signed [63:0] VMIN64 = -VMAX64 - 64'sd1;

  state_e state_q, state_d;

  logic [POS_W-1:0]             len_q;
  logic [IDX_W-1:0]             clr_q;
  logic                         out_valid_q;
  logic signed [DATA_W-1:0]     out_data_q;
  logic                         out_err_q;

  logic [IDX_W-1:0]             i_q;
  logic [CNT_W-1:0]             l_q, r_q;
  logic signed [VALUE_BITS-1:0] res_q, left_q, val_q;
  logic                         pend_q, err_q;

  // Request fields
  logic [POS_W-1:0]         in_pos, in_lo, in_hi;
  logic signed [DATA_W-1:0] in_value;
  logic                     in_cmd;

  assign in_pos   = s_axis_tdata[10:0];
  assign in_value = s_axis_tdata[42:11];
  assign in_lo    = s_axis_tdata[53:43];
  assign in_hi    = s_axis_tdata[64:54];
  assign in_cmd   = s_axis_tuser;

  logic             in_acc;
  logic             out_free;
  logic [EXT_W-1:0] len_eff, pos_x, lo_x, hi_x;
  logic             bad_pos, bad_rng, in_err, in_empty;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign cfg_ready_o   = 1'b1;

  assign len_eff = (EXT_W'(len_q) > EXT_W'(MAX_LEN)) ? EXT_W'(MAX_LEN) : EXT_W'(len_q);
  assign pos_x   = EXT_W'(in_pos);
  assign lo_x    = EXT_W'(in_lo);
  assign hi_x    = EXT_W'(in_hi);
  assign bad_pos = (pos_x == '0) || (pos_x > len_eff);
  assign bad_rng = (lo_x == '0) || (lo_x > len_eff) || (hi_x == '0) || (hi_x > len_eff);
  assign in_err  = (in_cmd == CMD_SET) ? bad_pos : bad_rng;
  assign in_empty = (in_cmd == CMD_QUERY) && (lo_x > hi_x);

  // Set value limited to the stored width.
  logic signed [63:0]           v64;
  logic signed [VALUE_BITS-1:0] set_val;

  assign v64     = 64'(in_value);
  assign set_val = (v64 > VMAX64) ? VMAX :
                   (v64 < VMIN64) ? VMIN : v64[VALUE_BITS-1:0];

  // Result limited to the 32-bit output.
  logic signed [63:0]       res64;
  logic signed [DATA_W-1:0] res_out;

  assign res64   = 64'(res_q);
  assign res_out = (res64 > OUT_MAX64) ? OUT_MAX :
                   (res64 < OUT_MIN64) ? OUT_MIN : res64[DATA_W-1:0];

  // Shared minimum and node memory
  logic signed [VALUE_BITS-1:0] min_a, min_b, min_y;
  logic                         ram_we;
  logic [IDX_W-1:0]             ram_addr;
  logic [VALUE_BITS-1:0]        ram_wdata, ram_rdata;
  logic [CNT_W-1:0]             r_dec;

  assign r_dec = r_q - CNT_W'(1);
  assign min_a = (state_q == ST_S_WR) ? left_q : res_q;
  assign min_b = ram_rdata;

  rmst_min_unit #(
    .WIDTH (VALUE_BITS)
  ) u_min (
    .a_i   (min_a),
    .b_i   (min_b),
    .min_o (min_y)
  );

  rmst_node_ram #(
    .DEPTH (TREE_SIZE),
    .WIDTH (VALUE_BITS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = '0;
    ram_wdata = VMAX;
    case (state_q)
      ST_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_q;
      end
      ST_S_LEAF: begin
        ram_we    = 1'b1;
        ram_addr  = i_q;
        ram_wdata = val_q;
      end
      ST_S_RDL: ram_addr = {i_q[IDX_W-2:0], 1'b0};
      ST_S_RDR: ram_addr = {i_q[IDX_W-2:0], 1'b1};
      ST_S_WR: begin
        ram_we    = 1'b1;
        ram_addr  = i_q;
        ram_wdata = min_y;
      end
      ST_Q_CHK: ram_addr = l_q[IDX_W-1:0];
      ST_Q_R:   ram_addr = r_dec[IDX_W-1:0];
      default: ;
    endcase
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == IDX_W'(TREE_SIZE - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) begin
          if (in_err || in_empty)     state_d = ST_FIN;
          else if (in_cmd == CMD_SET) state_d = ST_S_LEAF;
          else                        state_d = ST_Q_CHK;
        end
      end
      ST_S_LEAF: state_d = ST_S_RDL;
      ST_S_RDL:  state_d = ST_S_RDR;
      ST_S_RDR:  state_d = ST_S_WR;
      ST_S_WR: begin
        state_d = (i_q == IDX_W'(1)) ? ST_FIN : ST_S_RDL;
      end
      ST_Q_CHK: begin
        state_d = (l_q < r_q) ? ST_Q_R : ST_FIN;
      end
      ST_Q_R:  state_d = ST_Q_SH;
      ST_Q_SH: state_d = ST_Q_CHK;
      ST_FIN: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      len_q       <= ARRAY_LEN_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + IDX_W'(1);
      if (cfg_valid_i) len_q <= cfg_data_i;
      if (state_q == ST_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          i_q    <= IDX_W'(CNT_W'(MAX_LEN) + CNT_W'(in_pos) - CNT_W'(1));
          l_q    <= CNT_W'(MAX_LEN) + CNT_W'(in_lo) - CNT_W'(1);
          r_q    <= CNT_W'(MAX_LEN) + CNT_W'(in_hi);
          res_q  <= VMAX;
          val_q  <= set_val;
          err_q  <= in_err;
          pend_q <= 1'b0;
        end
      end
      ST_S_LEAF: i_q <= i_q >> 1;
      ST_S_RDR:  left_q <= ram_rdata;
      ST_S_WR: begin
        if (i_q != IDX_W'(1)) i_q <= i_q >> 1;
      end
      ST_Q_CHK: begin
        pend_q <= l_q[0];
        if (l_q[0]) l_q <= l_q + CNT_W'(1);
      end
      ST_Q_R: begin
        if (pend_q) res_q <= min_y;
        pend_q <= r_q[0];
        if (r_q[0]) r_q <= r_dec;
      end
      ST_Q_SH: begin
        if (pend_q) res_q <= min_y;
        l_q <= l_q >> 1;
        r_q <= r_q >> 1;
      end
      ST_FIN: begin
        if (out_free) begin
          out_data_q <= res_out;
          out_err_q  <= err_q;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_err_q;

endmodule

[rtl/rmst_node_ram.sv]
// ----------------------------------------------------------------------------
// rmst_node_ram: single-port node store of the segment tree
// One read or one write per cycle; read data is registered.
// ----------------------------------------------------------------------------
module rmst_node_ram #(
  parameter int unsigned DEPTH = 2048,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[addr_i];
  end

endmodule

[rtl/rmst_min_unit.sv]
// ----------------------------------------------------------------------------
// rmst_min_unit: shared signed minimum
// Serves both the ancestor refresh of a set and the fold of a query.
// ----------------------------------------------------------------------------
module rmst_min_unit #(
  parameter int unsigned WIDTH = 32
) (
  input  logic signed [WIDTH-1:0] a_i,
  input  logic signed [WIDTH-1:0] b_i,
  output logic signed [WIDTH-1:0] min_o
);

  // On a tie the first operand is kept.
  assign min_o = (b_i < a_i) ? b_i : a_i;

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range minimum segment tree testbench
// A short table of set and query requests is followed by random phases
// under different array lengths and idle patterns. Table rows with a known
// result are checked against the table, all others against a flat-array model.
// ----------------------------------------------------------------------------
module testbench
  import rmst_pkg::*;
();

  localparam int unsigned TREE_LEN    = 1024;
  localparam int unsigned QUIET_LIMIT = 20000;
  localparam int unsigned POS_TOP     = 2047;

  typedef struct packed {
    logic                     cmd;
    logic [POS_W-1:0]         pos;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         lo;
    logic [POS_W-1:0]         hi;
    logic                     known;
    logic signed [DATA_W-1:0] exp_min;
    logic                     exp_err;
  } stim_row_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] min_value;
    logic                     error;
  } tree_result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [POS_W-1:0]  cfg_data_i;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [71:0]       s_axis_tdata;
  logic              s_axis_tuser;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [DATA_W-1:0] m_axis_tdata;
  logic              m_axis_tuser;

  // Element values as seen by positions 1..TREE_LEN, and the length in force.
  logic signed [DATA_W-1:0] array_values [1:TREE_LEN];
  logic [POS_W-1:0]         cur_length;

  tree_result_t awaited_minima [$];
  tree_result_t oldest_result;
  int unsigned  mismatch_count;
  int unsigned  quiet_cycles;
  int unsigned  sender_idle_pct;
  int unsigned  receiver_stall_pct;

  stim_row_t directed_rows [24] = '{
    '{CMD_QUERY, 11'd0,    32'sd0,        11'd1,    11'd1024, 1'b1, OUT_MAX, 1'b0},
    '{CMD_SET,   11'd0,    32'sd7,        11'd0,    11'd0,    1'b1, OUT_MAX, 1'b1},
    '{CMD_SET,   11'd1025, 32'sd7,        11'd0,    11'd0,    1'b1, OUT_MAX, 1'b1},
    '{CMD_SET,   11'd2047, 32'sd7,        11'd0,    11'd0,    1'b1, OUT_MAX, 1'b1},
    '{CMD_SET,   11'd1,    OUT_MIN,       11'd0,    11'd0,    1'b1, OUT_MAX, 1'b0},
    '{CMD_SET,   11'd1024, OUT_MAX,       11'd0,    11'd0,    1'b1, OUT_MAX, 1'b0},
    '{CMD_SET,   11'd512,  32'sd0,        11'd0,    11'd0,    1'b1, OUT_MAX, 1'b0},
    '{CMD_SET,   11'd513,  -32'sd1,       11'd0,    11'd0,    1'b1, OUT_MAX, 1'b0},
    '{CMD_QUERY, 11'd0,    32'sd0,        11'd1,    11'd1,    1'b1, OUT_MIN, 1'b0},
    '{CMD_QUERY, 11'd0,    32'sd0,        11'd1024, 11'd1024, 1'b1, OUT_MAX, 1'b0},
    '{CMD_QUERY, 11'd0,    32'sd0,        11'd1,    11'd1024, 1'b1, OUT_MIN, 1'b0},
    '{CMD_QUERY, 11'd0,    32'sd0,        11'd2,    11'd1024, 1'b0, 32'sd0,  1'b0},
    '{CMD_QUERY, 11'd0,    32'sd0,        11'd512,  11'd512,  1'b1, 32'sd0,  1'b0},
    '{CMD_QUERY, 11'd0,    32'sd0,        11'd513,  11'd1024, 1'b0, 32'sd0,  1'b0},
    '{CMD_QUERY, 11'd0,    32'sd0,        11'd5,    11'd4,    1'b1, OUT_MAX, 1'b0},
    '{CMD_QUERY, 11'd0,    32'sd0,        11'd1024, 11'd1,    1'b1, OUT_MAX, 1'b0},
    '{CMD_QUERY, 11'd0,    32'sd0,        11'd0,    11'd5,    1'b1, OUT_MAX, 1'b1},
    '{CMD_QUERY, 11'd0,    32'sd0,        11'd5,    11'd0,    1'b1, OUT_MAX, 1'b1},
    '{CMD_QUERY, 11'd0,    32'sd0,        11'd1,    11'd1025, 1'b1, OUT_MAX, 1'b1},
    '{CMD_QUERY, 11'd0,    32'sd0,        11'd2047, 11'd2047, 1'b1, OUT_MAX, 1'b1},
    '{CMD_SET,   11'd300,  32'h5555_5555, 11'd0,    11'd0,    1'b1, OUT_MAX, 1'b0},
    '{CMD_SET,   11'd301,  32'hAAAA_AAAA, 11'd0,    11'd0,    1'b1, OUT_MAX, 1'b0},
    '{CMD_QUERY, 11'd0,    32'sd0,        11'd300,  11'd301,  1'b0, 32'sd0,  1'b0},
    '{CMD_QUERY, 11'd0,    32'sd0,        11'd0,    11'd0,    1'b1, OUT_MAX, 1'b1}
  };

  range_minimum_segment_tree #(
    .MAX_LEN    (TREE_LEN),
    .VALUE_BITS (DATA_W)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned effective_length();
    return (cur_length > TREE_LEN) ? TREE_LEN : cur_length;
  endfunction

  // Applies one request to the element array and returns its result. With
  // 32-bit values the saturation steps of the block change nothing.
  function automatic tree_result_t expected_tree_result(input stim_row_t row);
    tree_result_t res;
    int unsigned  len;
    int unsigned  p;
    len = effective_length();
    res.min_value = OUT_MAX;
    res.error = 1'b0;
    if (row.cmd == CMD_SET) begin
      if (row.pos == 0 || row.pos > len) begin
        res.error = 1'b1;
      end else begin
        array_values[row.pos] = row.value;
      end
    end else if (row.lo == 0 || row.lo > len || row.hi == 0 || row.hi > len) begin
      res.error = 1'b1;
    end else begin
      for (p = row.lo; p <= row.hi; p++) begin
        if (array_values[p] < res.min_value) begin
          res.min_value = array_values[p];
        end
      end
    end
    return res;
  endfunction

  // Mostly a legal position, sometimes zero or a position beyond the length.
  function automatic logic [POS_W-1:0] pick_position(input int unsigned len);
    if (len == 0 || $urandom_range(99) < 10) begin
      if ($urandom_range(1) == 0) begin
        return '0;
      end
      return POS_W'($urandom_range(POS_TOP, len + 1));
    end
    return POS_W'($urandom_range(len, 1));
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(19))
      0: return OUT_MIN;
      1: return OUT_MAX;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic stim_row_t random_request();
    stim_row_t   row;
    int unsigned len;
    int unsigned top;
    logic [POS_W-1:0] swap;
    len = effective_length();
    row.pos = POS_W'($urandom);
    row.value = $urandom;
    row.lo = POS_W'($urandom);
    row.hi = POS_W'($urandom);
    row.known = 1'b0;
    row.exp_min = '0;
    row.exp_err = 1'b0;
    if ($urandom_range(99) < 45) begin
      row.cmd = CMD_SET;
      row.pos = pick_position(len);
      row.value = pick_value();
    end else begin
      row.cmd = CMD_QUERY;
      row.lo = pick_position(len);
      if (row.lo != 0 && row.lo <= len && $urandom_range(99) < 40) begin
        top = row.lo + $urandom_range(15);
        row.hi = POS_W'((top > len) ? len : top);
      end else begin
        row.hi = pick_position(len);
      end
      // Keep most in-bounds ranges non-empty so that real minima come back.
      if (row.hi != 0 && row.hi <= len && row.lo > row.hi && $urandom_range(99) < 75) begin
        swap = row.lo;
        row.lo = row.hi;
        row.hi = swap;
      end
    end
    return row;
  endfunction

  task automatic send_request(input stim_row_t row);
    tree_result_t predicted;
    if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < sender_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= row.cmd;
    s_axis_tdata <= {7'd0, row.hi, row.lo, row.value, row.pos};
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    predicted = expected_tree_result(row);
    if (row.known) begin
      predicted = '{min_value: row.exp_min, error: row.exp_err};
    end
    awaited_minima.push_back(predicted);
  endtask

  task automatic wait_for_results();
    while (awaited_minima.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic write_length(input logic [POS_W-1:0] len);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= len;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    cfg_valid_i <= 1'b0;
    cur_length = len;
  endtask

  task automatic run_phase(input logic [POS_W-1:0] len, input int unsigned send_pct,
                           input int unsigned recv_pct, input int unsigned n_items);
    int unsigned k;
    wait_for_results();
    write_length(len);
    sender_idle_pct = send_pct;
    receiver_stall_pct = recv_pct;
    for (k = 0; k < n_items; k++) begin
      send_request(random_request());
    end
    s_axis_tvalid <= 1'b0;
  endtask

  // Result side: random stalls, checking, and a watchdog on progress.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (awaited_minima.size() == 0) begin
        $error("result with no request pending: min_value %0d, error %0b",
               $signed(m_axis_tdata), m_axis_tuser);
        mismatch_count++;
      end else begin
        oldest_result = awaited_minima.pop_front();
        if (m_axis_tdata !== oldest_result.min_value) begin
          $error("min_value: expected %0d, actual %0d",
                 oldest_result.min_value, $signed(m_axis_tdata));
          mismatch_count++;
        end
        if (m_axis_tuser !== oldest_result.error) begin
          $error("error: expected %0b, actual %0b", oldest_result.error, m_axis_tuser);
          mismatch_count++;
        end
      end
    end
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = CMD_SET;
    cur_length = ARRAY_LEN_RST;
    mismatch_count = 0;
    quiet_cycles = 0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    foreach (array_values[i]) begin
      array_values[i] = OUT_MAX;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i]);
    end
    s_axis_tvalid <= 1'b0;

    // Length above the tree size acts as the full size, zero rejects all.
    run_phase(11'd2047, 0, 0, 450);
    run_phase(11'd0, 88, 0, 100);
    run_phase(POS_W'($urandom_range(1023, 2)), 0, 88, 500);
    run_phase(11'd1, 37, 37, 150);
    run_phase(11'd1024, 37, 37, 550);

    wait_for_results();
    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
